// ===== rtl/radix_integer_to_text_macros.svh =====
// Assertion macros shared by the radix integer to text RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef RADIX_INTEGER_TO_TEXT_MACROS_SVH
`define RADIX_INTEGER_TO_TEXT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RIT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("radix_integer_to_text: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("radix_integer_to_text: next-cycle check failed");

`endif

// ===== rtl/rit_pkg.sv =====
// Package for the radix integer to text block: field widths, character constants,
// sequencer state type, divider control and status structs, and digit helpers.
`timescale 1ns / 1ps

package rit_pkg;

   localparam int VALUE_BITS = 64;
   localparam int RADIX_BITS = 6;
   localparam int CHAR_BITS  = 7;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN      = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX      = 6'd36;
   localparam logic [RADIX_BITS-1:0] DECIMAL_DIGITS = 6'd10;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO     = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE     = 7'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_LETTER_A = 7'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_LETTER_Z = 7'h5A;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FETCH,
      ST_LOAD,
      ST_SHOW
   } rit_state_type;

   typedef struct packed {
      logic start;
      logic resume;
   } rit_div_ctrl_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic                  quotient_zero;
      logic [RADIX_BITS-1:0] remainder;
   } rit_div_stat_type;

   // Bases below two act as two, bases above thirty-six act as thirty-six.
   function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
      logic [RADIX_BITS-1:0] result;
      if (r < RADIX_MIN) begin
         result = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         result = RADIX_MAX;
      end else begin
         result = r;
      end
      return result;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
      logic [CHAR_BITS-1:0] result;
      if (d < DECIMAL_DIGITS) begin
         result = CHAR_ZERO + {1'b0, d};
      end else begin
         result = CHAR_LETTER_A + {1'b0, d} - {1'b0, DECIMAL_DIGITS};
      end
      return result;
   endfunction

endpackage

// ===== rtl/rit_if.sv =====
// Handshake channel interfaces for the radix integer to text block.
// Depends on rit_pkg for the payload widths.
`timescale 1ns / 1ps

interface rit_req_if;
   import rit_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic [RADIX_BITS-1:0] radix;

   modport source (output valid, value, radix, input ready);
   modport sink   (input valid, value, radix, output ready);
endinterface

interface rit_rsp_if;
   import rit_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] char_code;
   logic                 last;

   modport source (output valid, char_code, last, input ready);
   modport sink   (input valid, char_code, last, output ready);
endinterface

// ===== rtl/radix_integer_to_text.sv =====
// Radix integer to text converter, top level: sequencer, digit pointer and output register.
// Depends on rit_pkg, rit_if, rit_divider, rit_digit_store and the assertion macro header.
//
// Each request transfer carries an unsigned value (only the low VALUE_WIDTH bits count) and a
// base; bases below two act as two and bases above thirty-six act as thirty-six. The block
// answers with one response transfer per digit, most significant digit first, as ASCII '0'-'9'
// then 'A'-'Z', and raises last on the least significant digit. A zero value gives a single
// '0'. At most MAX_DIGITS digits are produced; when the value needs more, only the lowest
// MAX_DIGITS digits appear and the higher ones are dropped. One conversion is in flight at a
// time: req_bus.ready is high only while the block is idle. A serial restoring divider finds
// one quotient bit per cycle to produce each digit, and each digit then leaves through a memory
// read, an output register load, and the transfer itself while rsp_bus.ready is high. There is
// no clearing pass after reset; every digit that is emitted was written by the same conversion.
`timescale 1ns / 1ps
`include "radix_integer_to_text_macros.svh"

module radix_integer_to_text #(
   parameter int VALUE_WIDTH = 64,
   parameter int MAX_DIGITS  = 64
) (
   input  logic         clock,
   input  logic         reset,
   rit_req_if.sink      req_bus,
   rit_rsp_if.source    rsp_bus
);
   import rit_pkg::*;

   localparam int AddrBits = $clog2(MAX_DIGITS);

   rit_state_type         state_ff, state_in;
   logic [AddrBits-1:0]   ptr_ff, ptr_in;
   logic [CHAR_BITS-1:0]  char_ff, char_in;
   logic                  last_ff, last_in;

   rit_div_ctrl_type      div_ctrl;
   rit_div_stat_type      div_stat;

   logic                  req_transfer;
   logic                  rsp_transfer;
   logic                  store_full;
   logic                  mem_wr_en;
   logic [RADIX_BITS-1:0] mem_rd_data;

   assign req_transfer = req_bus.valid && req_bus.ready;
   assign rsp_transfer = rsp_bus.valid && rsp_bus.ready;
   assign store_full   = ptr_ff == AddrBits'(MAX_DIGITS - 1);

   // The divider keeps the running quotient and the base between digits.
   rit_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .dividend (req_bus.value[VALUE_WIDTH-1:0]),
      .divisor  (clamp_radix(req_bus.radix)),
      .ctrl     (div_ctrl),
      .stat     (div_stat)
   );

   // Digits are written least significant first at rising addresses and read back
   // from the highest address down; the read port follows the pointer every cycle.
   rit_digit_store #(
      .DEPTH (MAX_DIGITS)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (div_stat.remainder),
      .rd_addr (ptr_ff),
      .rd_data (mem_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_transfer) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // Stop once the quotient runs out or the store is full.
            if (div_stat.done && (div_stat.quotient_zero || store_full)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_transfer) begin
               state_in = last_ff ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath control. Ready is high in the idle state and valid is high
   // in the show state, so the far side's handshake signal alone marks a transfer there.
   always_comb begin
      req_bus.ready   = 1'b0;
      rsp_bus.valid   = 1'b0;
      div_ctrl.start  = 1'b0;
      div_ctrl.resume = 1'b0;
      mem_wr_en       = 1'b0;
      ptr_in          = ptr_ff;
      char_in         = char_ff;
      last_in         = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready  = 1'b1;
            div_ctrl.start = req_bus.valid;
            if (req_bus.valid) begin
               ptr_in = '0;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               mem_wr_en = 1'b1;
               if (!div_stat.quotient_zero && !store_full) begin
                  div_ctrl.resume = 1'b1;
                  ptr_in          = ptr_ff + AddrBits'(1);
               end
            end
         end
         ST_FETCH: begin
         end
         ST_LOAD: begin
            char_in = digit_char(mem_rd_data);
            last_in = ptr_ff == '0;
         end
         ST_SHOW: begin
            rsp_bus.valid = 1'b1;
            if (rsp_bus.ready && !last_ff) begin
               ptr_in = ptr_ff - AddrBits'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_bus.char_code = char_ff;
   assign rsp_bus.last      = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   `RIT_ASSERT_SAME(a_ready_divider_free, clock, reset, req_bus.ready, !div_stat.busy)
   `RIT_ASSERT_SAME(a_done_only_dividing, clock, reset, div_stat.done, state_ff == ST_DIVIDE)
   `RIT_ASSERT_NEXT(a_last_ends_item, clock, reset,
                    rsp_transfer && rsp_bus.last, state_ff == ST_IDLE)
   `RIT_ASSERT_SAME(a_char_is_digit, clock, reset, rsp_bus.valid,
                    (rsp_bus.char_code >= CHAR_ZERO && rsp_bus.char_code <= CHAR_NINE) ||
                    (rsp_bus.char_code >= CHAR_LETTER_A && rsp_bus.char_code <= CHAR_LETTER_Z))

endmodule

// ===== rtl/rit_divider.sv =====
// Bit-serial restoring divider: divides a VALUE_WIDTH-bit word by a small radix,
// one quotient bit per cycle. Depends on rit_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "radix_integer_to_text_macros.svh"

module rit_divider #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [VALUE_WIDTH-1:0]         dividend,
   input  logic [rit_pkg::RADIX_BITS-1:0] divisor,
   input  rit_pkg::rit_div_ctrl_type      ctrl,
   output rit_pkg::rit_div_stat_type      stat
);
   import rit_pkg::*;

   localparam int CountBits = $clog2(VALUE_WIDTH);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CountBits-1:0]  count_ff, count_in;
   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [RADIX_BITS-1:0] rem_ff, rem_in;
   logic [RADIX_BITS-1:0] divisor_ff, divisor_in;

   logic [RADIX_BITS:0]   partial;
   logic                  fits;
   logic [RADIX_BITS:0]   trial;
   logic                  last_step;

   // The partial remainder stays below the divisor, so one shifted-in bit
   // never carries it past seven bits.
   assign partial   = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign fits      = partial >= {1'b0, divisor_ff};
   assign trial     = partial - {1'b0, divisor_ff};
   assign last_step = count_ff == CountBits'(VALUE_WIDTH - 1);

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (ctrl.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (ctrl.resume) begin
         // The previous quotient is already in place as the next dividend.
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[VALUE_WIDTH-2:0], fits};
         rem_in   = fits ? trial[RADIX_BITS-1:0] : partial[RADIX_BITS-1:0];
         count_in = count_ff + CountBits'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign stat.busy          = busy_ff;
   assign stat.done          = done_ff;
   assign stat.quotient_zero = quot_ff == '0;
   assign stat.remainder     = rem_ff;

   `RIT_ASSERT_SAME(a_done_not_busy, clock, reset, done_ff, !busy_ff)
   `RIT_ASSERT_SAME(a_launch_when_free, clock, reset, ctrl.start || ctrl.resume, !busy_ff)
   `RIT_ASSERT_NEXT(a_last_step_done, clock, reset,
                    busy_ff && last_step && !ctrl.start && !ctrl.resume, done_ff && !busy_ff)

endmodule

// ===== rtl/rit_digit_store.sv =====
// Digit memory: one write port and one read port with registered read data.
// Depends on rit_pkg for the digit width.
`timescale 1ns / 1ps

module rit_digit_store #(
   parameter int DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [rit_pkg::RADIX_BITS-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [rit_pkg::RADIX_BITS-1:0] rd_data
);
   import rit_pkg::*;

   logic [RADIX_BITS-1:0] mem [DEPTH];
   logic [RADIX_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
